>>> rtl/ibusfr_pkg.sv
// Shared types and constants for the iBus frame receiver.
package ibusfr_pkg;

    localparam int MAX_CHANNELS = 16;
    localparam int STORE_WORDS  = MAX_CHANNELS;
    localparam int WORD_AW      = $clog2(STORE_WORDS);
    localparam int COUNT_W      = $clog2(2 * MAX_CHANNELS + 1);

    localparam logic [7:0] HDR_FIRST  = 8'h20;
    localparam logic [7:0] HDR_SECOND = 8'h40;

    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_READ = 1'b1;

    localparam logic [4:0] CHANNEL_COUNT_RST = 5'd14;

    typedef struct packed {
        logic       opcode;
        logic [7:0] rx_byte;
        logic [4:0] channel_number;
    } t_req;

    typedef struct packed {
        logic [15:0] channel_value;
        logic        frame_ready;
    } t_rsp;

endpackage

>>> rtl/ibusfr_core.sv
// Frame parser, channel store and ready flag; result formed in the same cycle.
module ibusfr_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [4:0]         i_cfg_wdata,
    input  logic               i_take,
    input  ibusfr_pkg::t_req   i_req,
    output ibusfr_pkg::t_rsp   o_rsp
);
    import ibusfr_pkg::*;

    logic [15:0]        r_store [STORE_WORDS];
    logic [COUNT_W-1:0] r_byte_count;
    logic [COUNT_W-1:0] n_byte_count;
    logic               r_collecting;
    logic               n_collecting;
    logic [7:0]         r_last_byte;
    logic               r_ready;
    logic               n_ready;
    logic [4:0]         r_channel_count;
    logic [4:0]         eff_count;
    logic [COUNT_W-1:0] frame_len;
    logic               store_we;
    logic [WORD_AW-1:0] rd_idx;
    logic [15:0]        rd_word;
    logic [15:0]        value;

    // Hold the channel count within 1..MAX_CHANNELS.
    always_comb begin
        if (r_channel_count == 5'd0) begin
            eff_count = 5'd1;
        end else if (r_channel_count > 5'(MAX_CHANNELS)) begin
            eff_count = 5'(MAX_CHANNELS);
        end else begin
            eff_count = r_channel_count;
        end
        frame_len = {eff_count, 1'b0};
    end

    assign rd_idx  = WORD_AW'(i_req.channel_number - 5'd1);
    assign rd_word = r_store[rd_idx];

    always_comb begin
        n_byte_count = r_byte_count;
        n_collecting = r_collecting;
        n_ready      = r_ready;
        store_we     = 1'b0;
        value        = 16'd0;
        case (i_req.opcode)
            OP_BYTE: begin
                if (i_req.rx_byte == HDR_SECOND && r_last_byte == HDR_FIRST) begin
                    n_collecting = 1'b1;
                    n_byte_count = '0;
                end else if (r_collecting) begin
                    if (r_byte_count < frame_len) begin
                        store_we     = 1'b1;
                        n_byte_count = r_byte_count + COUNT_W'(1);
                        if (n_byte_count >= frame_len) begin
                            n_ready      = 1'b1;
                            n_collecting = 1'b0;
                        end
                    end else begin
                        n_collecting = 1'b0;
                    end
                end
            end
            OP_READ: begin
                if (i_req.channel_number >= 5'd1 &&
                    i_req.channel_number <= 5'(MAX_CHANNELS)) begin
                    value = rd_word;
                end
                n_ready = 1'b0;
            end
            default: begin
                n_ready = r_ready;
            end
        endcase
    end

    assign o_rsp.channel_value = value;
    assign o_rsp.frame_ready   = n_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_count    <= '0;
            r_collecting    <= 1'b0;
            r_last_byte     <= 8'd0;
            r_ready         <= 1'b0;
            r_channel_count <= CHANNEL_COUNT_RST;
        end else begin
            if (i_cfg_we) begin
                r_channel_count <= i_cfg_wdata;
            end
            if (i_take) begin
                r_byte_count <= n_byte_count;
                r_collecting <= n_collecting;
                r_ready      <= n_ready;
                if (i_req.opcode == OP_BYTE) begin
                    r_last_byte <= i_req.rx_byte;
                end
            end
        end
    end

    // Store is cleared at reset; low byte at even slots, high byte at odd.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < STORE_WORDS; i++) begin
                r_store[i] <= 16'd0;
            end
        end else if (i_take && store_we) begin
            if (r_byte_count[0]) begin
                r_store[r_byte_count[WORD_AW:1]][15:8] <= i_req.rx_byte;
            end else begin
                r_store[r_byte_count[WORD_AW:1]][7:0] <= i_req.rx_byte;
            end
        end
    end

endmodule

>>> rtl/ibus_frame_receiver_unit.sv
// Top level of the iBus frame receiver: request intake, result register and skid stage.
//
// Usage:
//  - Request channel: i_in_valid / o_in_stall / i_in_req. A request is taken at a
//    rising edge with i_in_valid high and o_in_stall low. opcode 0 carries one
//    received serial byte, opcode 1 reads a one-based channel.
//  - Result channel: o_out_valid / i_out_stall / o_out_rsp. Every request gives
//    exactly one result: the channel value (zero for a byte) and the ready flag.
//  - Config: i_cfg_we / i_cfg_wdata write channel_count; write only when idle.
//  - Timing: the result is loaded into the result register at the edge that takes
//    the request, or into the skid stage while the result register is stalled.
//    Throughput: one request per cycle while o_in_stall is low.
//  - Stall: when i_out_stall holds a result, one more request is caught in the
//    skid stage; only then is o_in_stall raised, until the result drains.
//  - Reset (synchronous, active low): flag, counters, header tracking and the
//    whole channel store clear at once; channel_count returns to 14. No
//    clearing pass is needed, so requests are taken right after reset.
module ibus_frame_receiver_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [4:0]         i_cfg_wdata,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  ibusfr_pkg::t_req   i_in_req,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output ibusfr_pkg::t_rsp   o_out_rsp
);
    import ibusfr_pkg::*;

    logic r_out_valid;
    logic r_skid_valid;
    t_rsp r_out_rsp;
    t_rsp r_skid_rsp;
    t_rsp core_rsp;
    logic take;
    logic out_free;

    // Accept whenever the skid stage is empty.
    assign o_in_stall = r_skid_valid;
    assign take       = i_in_valid && !r_skid_valid;
    // Result register can load when empty or being drained this edge.
    assign out_free   = !r_out_valid || !i_out_stall;

    ibusfr_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_take      (take),
        .i_req       (i_in_req),
        .o_rsp       (core_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (out_free) begin
                // Drain the skid first, else load the new result directly.
                if (r_skid_valid) begin
                    r_out_valid  <= 1'b1;
                    r_skid_valid <= 1'b0;
                end else begin
                    r_out_valid <= take;
                end
            end else if (take) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    // Payload registers, no reset needed.
    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_skid_valid) begin
                r_out_rsp <= r_skid_rsp;
            end else if (take) begin
                r_out_rsp <= core_rsp;
            end
        end else if (take) begin
            r_skid_rsp <= core_rsp;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_rsp   = r_out_rsp;

    // Skid holds data only behind a waiting result.
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid stage full with empty result register");

    // A request taken while the result waits lands in the skid.
    a_take_into_skid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && r_out_valid && i_out_stall) |=> r_skid_valid)
        else $error("request lost while result stalled");

    // A skid entry moves to the result register once the stall lifts.
    a_skid_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && !i_out_stall) |=> (r_out_valid && !r_skid_valid))
        else $error("skid stage failed to drain");

    // A byte request never returns a channel value.
    a_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && i_in_req.opcode == OP_BYTE) |-> (core_rsp.channel_value == 16'd0))
        else $error("nonzero value for byte request");

endmodule
